// ===== design/mtls_pkg.sv =====
package mtls_pkg;

	// Table geometry
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MAX_LINE = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int LEN_W    = $clog2(MAX_LINE + 1);

	// Field widths
	localparam int DATA_W    = 32;
	localparam int IDX_W     = 6;
	localparam int REQ_W     = 3;
	localparam int DIM_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 32;

	// Request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_GET     = 3'd0,
		REQ_SET     = 3'd1,
		REQ_ADD     = 3'd2,
		REQ_ROW_SUM = 3'd3,
		REQ_COL_SUM = 3'd4,
		REQ_FILL    = 3'd5
	} req_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL = 2'd2;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GET,
		ST_GETD,
		ST_SET,
		ST_ADD,
		ST_ADDW,
		ST_SUM,
		ST_SUMT,
		ST_FILL,
		ST_DONE
	} state_t;

	// One request item
	typedef struct packed {
		req_t              kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] data;
	} item_t;

	// Effective dimensions and fill value
	typedef struct packed {
		logic [LEN_W-1:0]  rows;
		logic [LEN_W-1:0]  cols;
		logic [DATA_W-1:0] fill;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              ok;
	} res_t;

	// Cell store port group
	typedef struct packed {
		logic              re;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} ram_req_t;

endpackage

// ===== design/mtls_cell_ram.sv =====
module mtls_cell_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mtls_seq.sv =====
module mtls_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mtls_pkg::item_t        item,
	input  mtls_pkg::cfg_t         cfg,
	output logic                   res_valid,
	input  logic                   res_ready,
	output mtls_pkg::res_t         res,
	output mtls_pkg::ram_req_t     ram_req,
	input  logic [mtls_pkg::DATA_W-1:0] ram_rdata
);
	import mtls_pkg::*;

	state_t            state_q, state_d;
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] acc_q;
	logic              ok_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] stride_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  rcnt_q;
	logic [LEN_W-1:0]  len_q;

	logic              row_ok, col_ok, item_ok;
	logic [ADDR_W-1:0] start_addr;
	logic              accept;
	logic              line_last, row_last;
	logic [DATA_W-1:0] add_a, add_y;

	// Index checks against the dimensions in use
	assign row_ok = int'(item.row) < int'(cfg.rows);
	assign col_ok = int'(item.col) < int'(cfg.cols);
	assign accept = in_valid && in_ready;

	always_comb begin
		item_ok    = 1'b0;
		start_addr = '0;
		case (item.kind)
			REQ_GET, REQ_SET, REQ_ADD: begin
				item_ok    = row_ok && col_ok;
				start_addr = ADDR_W'(int'(item.row) * MAX_COLS + int'(item.col));
			end
			REQ_ROW_SUM: begin
				item_ok    = row_ok;
				start_addr = ADDR_W'(int'(item.row) * MAX_COLS);
			end
			REQ_COL_SUM: begin
				item_ok    = col_ok;
				start_addr = ADDR_W'(int'(item.col));
			end
			REQ_FILL: begin
				item_ok = 1'b1;
			end
			default: begin
				item_ok = 1'b0;
			end
		endcase
	end

	assign line_last = (cnt_q == LEN_W'(len_q - LEN_W'(1)));
	assign row_last  = (rcnt_q == LEN_W'(cfg.rows - LEN_W'(1)));

	// Shared adder: accumulate a line, or add to a cell
	assign add_a = (state_q == ST_ADDW) ? data_q : acc_q;
	assign add_y = add_a + ram_rdata;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		ram_req.re    = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.addr  = addr_q;
		ram_req.wdata = data_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DONE;
					case (item.kind)
						REQ_GET:     if (item_ok) state_d = ST_GET;
						REQ_SET:     if (item_ok) state_d = ST_SET;
						REQ_ADD:     if (item_ok) state_d = ST_ADD;
						REQ_ROW_SUM: if (item_ok && cfg.cols != '0) state_d = ST_SUM;
						REQ_COL_SUM: if (item_ok && cfg.rows != '0) state_d = ST_SUM;
						REQ_FILL: begin
							if (cfg.rows != '0 && cfg.cols != '0) state_d = ST_FILL;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_GET: begin
				ram_req.re = 1'b1;
				state_d    = ST_GETD;
			end
			ST_GETD: begin
				state_d = ST_DONE;
			end
			ST_SET: begin
				ram_req.we = 1'b1;
				state_d    = ST_DONE;
			end
			ST_ADD: begin
				ram_req.re = 1'b1;
				state_d    = ST_ADDW;
			end
			ST_ADDW: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = add_y;
				state_d       = ST_DONE;
			end
			ST_SUM: begin
				ram_req.re = 1'b1;
				if (line_last) state_d = ST_SUMT;
			end
			ST_SUMT: begin
				state_d = ST_DONE;
			end
			ST_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = cfg.fill;
				if (line_last && row_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q   <= item.data;
			acc_q    <= '0;
			ok_q     <= item_ok;
			addr_q   <= start_addr;
			base_q   <= '0;
			cnt_q    <= '0;
			rcnt_q   <= '0;
			len_q    <= (item.kind == REQ_COL_SUM) ? cfg.rows : cfg.cols;
			stride_q <= (item.kind == REQ_COL_SUM) ? ADDR_W'(MAX_COLS) : ADDR_W'(1);
		end else begin
			case (state_q)
				ST_GETD: begin
					acc_q <= ram_rdata;
				end
				ST_SUM: begin
					// the read data is registered, so it belongs to the previous read
					if (cnt_q != '0) acc_q <= add_y;
					addr_q <= addr_q + stride_q;
					cnt_q  <= cnt_q + LEN_W'(1);
				end
				ST_SUMT: begin
					acc_q <= add_y;
				end
				ST_FILL: begin
					if (line_last) begin
						cnt_q  <= '0;
						rcnt_q <= rcnt_q + LEN_W'(1);
						base_q <= base_q + ADDR_W'(MAX_COLS);
						addr_q <= base_q + ADDR_W'(MAX_COLS);
					end else begin
						cnt_q  <= cnt_q + LEN_W'(1);
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign res.value = acc_q;
	assign res.ok    = ok_q;

endmodule

// ===== design/matrix_table_with_line_sums_core.sv =====
// Bounds-checked 16 x 16 table of 32-bit signed cells with get, set, add, row sum,
// column sum and fill requests; every request gives exactly one result item. A single
// sequencer drives one cell memory (one read and one write port, registered read) and one
// shared 32-bit adder, and takes no new item until the current one has left it. A bad index,
// an unused code, an empty line or an empty fill goes straight to the result without touching
// the memory. The next item can be accepted in the cycle after the result is loaded into the
// output register. The sums and the fill are bound by the memory port, one cell per cycle. A
// result waiting in the output register does not stop the next item from being accepted.
// Cells are undefined until written by set, add or fill.
module matrix_table_with_line_sums_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mtls_pkg::S_TDATA_W-1:0]    s_tdata,  // row_index, col_index, data_value, pad
	input  logic [mtls_pkg::S_TUSER_W-1:0]    s_tuser,  // req_type
	// master side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mtls_pkg::M_TDATA_W-1:0]    m_tdata,  // result_value
	output logic [0:0]                        m_tuser,  // index_ok
	// configuration
	input  logic                              cfg_we,
	input  logic [mtls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtls_pkg::DATA_W-1:0]       cfg_data
);
	import mtls_pkg::*;

	logic [DIM_W-1:0]  rows_q;
	logic [DIM_W-1:0]  cols_q;
	logic [DATA_W-1:0] fill_q;
	cfg_t              cfg;
	item_t             item;
	res_t              res, out_res_q;
	logic              res_valid, res_ready;
	logic              out_valid_q;
	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 5'd16;
			cols_q <= 5'd16;
			fill_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data[DIM_W-1:0];
				CFG_COLS: cols_q <= cfg_data[DIM_W-1:0];
				CFG_FILL: fill_q <= cfg_data;
				default:  fill_q <= fill_q;
			endcase
		end
	end

	// Effective dimensions, capped at the table size
	assign cfg.rows = (int'(rows_q) > MAX_ROWS) ? LEN_W'(MAX_ROWS) : LEN_W'(rows_q);
	assign cfg.cols = (int'(cols_q) > MAX_COLS) ? LEN_W'(MAX_COLS) : LEN_W'(cols_q);
	assign cfg.fill = fill_q;

	// Input unpack
	assign item.kind = req_t'(s_tuser[REQ_W-1:0]);
	assign item.row  = s_tdata[IDX_W-1:0];
	assign item.col  = s_tdata[2*IDX_W-1:IDX_W];
	assign item.data = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

	mtls_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	mtls_cell_ram #(
		.DATA_W (DATA_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.addr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.addr),
		.rdata (ram_rdata)
	);

	// Output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_res_q.value;
	assign m_tuser[0] = out_res_q.ok;

endmodule

// ===== design/mtls_checker.sv =====
module mtls_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [mtls_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [0:0]                        m_tuser
);
	import mtls_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A result with index_ok clear always reads as zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("nonzero result with index_ok clear");

	// The block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted back to back");

	// No result appears without the block having been busy
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a request in flight");

endmodule

bind matrix_table_with_line_sums_core mtls_checker u_mtls_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
	import mtls_pkg::*;

	// Unused request codes, no operation in the block
	localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;
	localparam int N_SHAPES = 9;
	localparam int SHAPE_ITEMS = 72;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // row_index, col_index, data_value, pad
	logic [S_TUSER_W-1:0] s_tuser = '0;  // req_type
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;       // result_value
	logic [0:0] m_tuser;                 // index_ok
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	matrix_table_with_line_sums_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Directed request with an optional hand-written answer
	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] data;
		logic              typed;
		logic [DATA_W-1:0] value;
		logic              ok;
	} step_t;

	step_t plan [23] = '{
		'{REQ_FILL,     0,  0, 32'h0,        1, 32'h0,        1},
		'{REQ_GET,      0,  0, 32'h0,        1, 32'h0,        1},
		'{REQ_SET,     15, 15, 32'h7fffffff, 1, 32'h0,        1},
		'{REQ_GET,     15, 15, 32'h0,        1, 32'h7fffffff, 1},
		'{REQ_ADD,     15, 15, 32'h1,        1, 32'h0,        1},
		'{REQ_GET,     15, 15, 32'h0,        1, 32'h80000000, 1},
		'{REQ_SET,      0,  0, 32'h80000000, 1, 32'h0,        1},
		'{REQ_ADD,      0,  0, 32'hffffffff, 1, 32'h0,        1},
		'{REQ_GET,      0,  0, 32'h0,        1, 32'h7fffffff, 1},
		'{REQ_SET,      7,  9, 32'h12345678, 0, 32'h0,        0},
		'{REQ_GET,     16,  0, 32'h0,        1, 32'h0,        0},
		'{REQ_GET,      0, 16, 32'h0,        1, 32'h0,        0},
		'{REQ_SET,     63, 63, 32'hdeadbeef, 1, 32'h0,        0},
		'{REQ_ADD,      0, 63, 32'h1,        1, 32'h0,        0},
		'{REQ_GET,      7,  9, 32'h0,        0, 32'h0,        0},
		'{REQ_ROW_SUM, 15, 63, 32'h0,        0, 32'h0,        0},
		'{REQ_COL_SUM, 63,  0, 32'h0,        0, 32'h0,        0},
		'{REQ_ROW_SUM, 16,  0, 32'h0,        1, 32'h0,        0},
		'{REQ_COL_SUM,  0, 63, 32'h0,        1, 32'h0,        0},
		'{REQ_RSVD6,    3,  3, 32'h5,        1, 32'h0,        0},
		'{REQ_RSVD7,    0,  0, 32'h0,        1, 32'h0,        0},
		'{REQ_FILL,    63, 63, 32'hffffffff, 1, 32'h0,        1},
		'{REQ_ROW_SUM,  0,  0, 32'h0,        1, 32'h0,        1}
	};

	// Shadow table and registers
	logic [DATA_W-1:0] cells [DEPTH];
	logic [DIM_W-1:0]  rows_reg = 5'd16;
	logic [DIM_W-1:0]  cols_reg = 5'd16;
	logic [DATA_W-1:0] fill_reg = '0;

	res_t answers_q [$];
	int errors = 0;
	int n_results = 0;
	int kind_count [8];
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int hold_len = 0;
	logic [IDX_W-1:0] last_row = '0;
	logic [IDX_W-1:0] last_col = '0;

	function automatic int rows_live();
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int cols_live();
		return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	// Apply one request to the shadow table and return its answer
	function automatic res_t table_apply(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic [DATA_W-1:0] data);
		res_t ans;
		int nr;
		int nc;
		int a;
		nr = rows_live();
		nc = cols_live();
		ans = '0;
		a = int'(row) * MAX_COLS + int'(col);
		case (kind)
			REQ_GET, REQ_SET, REQ_ADD: begin
				if (row < nr && col < nc) begin
					ans.ok = 1'b1;
					if (kind == REQ_GET)
						ans.value = cells[a];
					else if (kind == REQ_SET)
						cells[a] = data;
					else
						cells[a] = cells[a] + data;
				end
			end
			REQ_ROW_SUM: begin
				if (row < nr) begin
					ans.ok = 1'b1;
					for (int i = 0; i < nc; i++)
						ans.value += cells[int'(row) * MAX_COLS + i];
				end
			end
			REQ_COL_SUM: begin
				if (col < nc) begin
					ans.ok = 1'b1;
					for (int i = 0; i < nr; i++)
						ans.value += cells[i * MAX_COLS + int'(col)];
				end
			end
			REQ_FILL: begin
				ans.ok = 1'b1;
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++)
						cells[i * MAX_COLS + j] = fill_reg;
			end
			default: ;
		endcase
		return ans;
	endfunction

	task automatic report(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("mismatch in %s at result %0d: got %h, expected %h",
			what, n_results, got, want);
		errors++;
	endtask

	// Offer one item; called and returning at a falling edge
	task automatic offer(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] data,
			input bit typed, input res_t want);
		res_t ans;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0, data, col, row};
		do @(posedge clk); while (!s_tready);
		ans = table_apply(kind, row, col, data);
		answers_q.push_back(typed ? want : ans);
		kind_count[kind]++;
		@(negedge clk);
	endtask

	// Wait for all answers, then let the sequencer settle
	task automatic drain();
		while (answers_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			CFG_ROWS: rows_reg = val[DIM_W-1:0];
			CFG_COLS: cols_reg = val[DIM_W-1:0];
			CFG_FILL: fill_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_shape(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
			input logic [DATA_W-1:0] fill);
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] c;
		// upper bits of the dimension writes are don't-care
		r = $urandom();
		c = $urandom();
		r[DIM_W-1:0] = rows;
		c[DIM_W-1:0] = cols;
		write_reg(CFG_ROWS, r);
		write_reg(CFG_COLS, c);
		write_reg(CFG_FILL, fill);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [IDX_W-1:0] pick_index(int limit);
		if (limit > 0 && $urandom_range(0, 9) < 8)
			return IDX_W'($urandom_range(0, limit - 1));
		if ($urandom_range(0, 1) == 0)
			return IDX_W'(limit);
		return IDX_W'($urandom_range(0, 63));
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'hffffffff;
			3: return 32'h1;
			default: return $urandom();
		endcase
	endfunction

	// Mostly valid requests in the live area, with some bad indexes and unused codes
	task automatic random_run(input int count, input bit with_hold);
		logic [REQ_W-1:0] kind;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		int p;
		for (int n = 0; n < count; n++) begin
			if (with_hold && n == 10)
				hold_len = 120;
			p = $urandom_range(0, 99);
			if (p < 24) kind = REQ_GET;
			else if (p < 44) kind = REQ_SET;
			else if (p < 64) kind = REQ_ADD;
			else if (p < 76) kind = REQ_ROW_SUM;
			else if (p < 88) kind = REQ_COL_SUM;
			else if (p < 95) kind = REQ_FILL;
			else if (p < 98) kind = REQ_RSVD6;
			else kind = REQ_RSVD7;
			row = pick_index(rows_live());
			col = pick_index(cols_live());
			// read back the cell just touched now and then
			if (kind == REQ_GET && $urandom_range(0, 2) == 0) begin
				row = last_row;
				col = last_col;
			end
			if (kind == REQ_SET || kind == REQ_ADD) begin
				last_row = row;
				last_col = col;
			end
			offer(kind, row, col, pick_data(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;
	endtask

	// Result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (answers_q.size() == 0) begin
				report("unexpected result", m_tdata, '0);
			end else begin
				want = answers_q.pop_front();
				if (m_tdata !== want.value)
					report("result_value", m_tdata, want.value);
				if (m_tuser[0] !== want.ok)
					report("index_ok", {31'b0, m_tuser[0]}, {31'b0, want.ok});
			end
		end
	end

	// Receiver: short random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
				m_tready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	// Stimulus
	initial begin
		logic [DIM_W-1:0] shape_rows [N_SHAPES];
		logic [DIM_W-1:0] shape_cols [N_SHAPES];
		logic [DATA_W-1:0] fill;
		shape_rows = '{1, 16, 0, 31, 7, 16, 3, 12, 16};
		shape_cols = '{1, 16, 0, 17, 16, 2, 9, 5, 16};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part on the reset shape; the first fill covers every cell
		foreach (plan[i])
			offer(plan[i].kind, plan[i].row, plan[i].col, plan[i].data,
				plan[i].typed, res_t'{plan[i].value, plan[i].ok});
		s_tvalid <= 1'b0;
		drain();

		// random part over several table shapes, quiet handshakes at the end
		for (int s = 0; s < N_SHAPES; s++) begin
			if (s == 0)
				fill = 32'h80000000;
			else if (s == 1)
				fill = 32'h7fffffff;
			else
				fill = $urandom();
			if (s == N_SHAPES - 1) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			set_shape(shape_rows[s], shape_cols[s], fill);
			random_run(SHAPE_ITEMS, s == 1);
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Requests: get %0d, set %0d, add %0d, row sum %0d, column sum %0d, fill %0d,",
			kind_count[REQ_GET], kind_count[REQ_SET], kind_count[REQ_ADD],
			kind_count[REQ_ROW_SUM], kind_count[REQ_COL_SUM], kind_count[REQ_FILL]);
		$display("  unused %0d; %0d results checked over %0d table shapes, %0d mismatches",
			kind_count[REQ_RSVD6] + kind_count[REQ_RSVD7], n_results, N_SHAPES + 1, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
